[rtl/gsj_pkg.sv]
// Shared types and constants for the Gaussian sum and Jacobian evaluator.
// Used by gsj_mul, gsj_div, gsj_table and gaussian_sum_jacobian_2d.
`timescale 1ns / 1ps
package gsj_pkg;

    localparam logic [63:0] INV2PI_Q64   = 64'h28BE60DB9391054A;
    localparam logic [63:0] LOG2E_M1_Q32 = 64'd1901360723;
    localparam logic [63:0] LN2_Q32      = 64'd2977044472;
    localparam logic [63:0] ONE_Q32      = 64'h0000_0001_0000_0000;
    localparam logic [63:0] TWO_Q32      = 64'h0000_0002_0000_0000;
    localparam logic [63:0] RECIP_NUM    = 64'h0100_0000_0000_0000;
    localparam logic [63:0] TX_LIMIT     = 64'h0000_0000_2000_0000;
    localparam logic [63:0] U_LIMIT      = 64'h0000_0020_0000_0000;
    localparam logic [63:0] SUM_BIAS     = 64'h8000_0000_0000_0000;
    localparam logic [63:0] POS48        = 64'h0000_7FFF_FFFF_FFFF;
    localparam logic [63:0] NEG48        = 64'h0000_8000_0000_0000;
    localparam logic [3:0]  EXP_TERMS    = 4'd12;
    localparam logic [5:0]  EXP_NMAX     = 6'd32;
    localparam int          ENTRY_W      = 120;

    typedef enum logic [4:0] {
        S_IDLE, S_RD, S_LD, S_DIV_R, S_MUL_SS, S_DIV_INV, S_MUL_TX, S_MUL_TY,
        S_CHK, S_MUL_TXX, S_MUL_TYY, S_CHKU, S_MUL_W1, S_MUL_W2, S_EXPN,
        S_MUL_Y, S_MUL_T, S_DIV_T, S_MUL_H, S_MUL_G, S_MUL_GS, S_MUL_DX,
        S_MUL_DY, S_MUL_DS, S_SUM, S_OUT
    } t_state;

    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [63:0] b;
        logic [5:0]  sh;
    } t_mul_req;

    typedef struct packed {
        logic        done;
        logic        ovf;
        logic [63:0] p;
    } t_mul_rsp;

    typedef struct packed {
        logic        start;
        logic [63:0] n;
        logic [63:0] d;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [63:0] q;
    } t_div_rsp;

endpackage

[rtl/gsj_mul.sv]
// Shared 64x64 multiplier: four 32x32 partial products over several cycles,
// then a right shift with saturation to 64 bits. Depends on gsj_pkg.
`timescale 1ns / 1ps
module gsj_mul (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  gsj_pkg::t_mul_req i_req,
    output gsj_pkg::t_mul_rsp o_rsp
);
    import gsj_pkg::*;

    logic         r_busy;
    logic [2:0]   r_step;
    logic [63:0]  r_a;
    logic [63:0]  r_b;
    logic [5:0]   r_sh;
    logic [63:0]  r_pp;
    logic [1:0]   r_ppk;
    logic [127:0] r_acc;
    logic [31:0]  pa;
    logic [31:0]  pb;
    logic [63:0]  pp_c;
    logic [1:0]   ppk_c;
    logic [127:0] pp_ext;
    logic [127:0] shifted;

    always_comb begin
        case (r_step)
            3'd0: begin pa = r_a[31:0];  pb = r_b[31:0];  ppk_c = 2'd0; end
            3'd1: begin pa = r_a[31:0];  pb = r_b[63:32]; ppk_c = 2'd1; end
            3'd2: begin pa = r_a[63:32]; pb = r_b[31:0];  ppk_c = 2'd1; end
            3'd3: begin pa = r_a[63:32]; pb = r_b[63:32]; ppk_c = 2'd2; end
            default: begin pa = 32'd0; pb = 32'd0; ppk_c = 2'd0; end
        endcase
        pp_c = pa * pb;
        case (r_ppk)
            2'd0:    pp_ext = {64'd0, r_pp};
            2'd1:    pp_ext = {32'd0, r_pp, 32'd0};
            default: pp_ext = {r_pp, 64'd0};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= 3'd0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_step <= 3'd0;
        end else if (r_busy) begin
            if (r_step == 3'd5) begin
                r_busy <= 1'b0;
            end else begin
                r_step <= r_step + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a   <= i_req.a;
            r_b   <= i_req.b;
            r_sh  <= i_req.sh;
            r_acc <= '0;
        end else if (r_busy) begin
            if (r_step < 3'd4) begin
                r_pp  <= pp_c;
                r_ppk <= ppk_c;
            end
            if (r_step >= 3'd1 && r_step <= 3'd4) begin
                r_acc <= r_acc + pp_ext;
            end
        end
    end

    assign shifted    = r_acc >> r_sh;
    assign o_rsp.done = r_busy && (r_step == 3'd5);
    assign o_rsp.ovf  = |shifted[127:64];
    assign o_rsp.p    = (|shifted[127:64]) ? {64{1'b1}} : shifted[63:0];

endmodule

[rtl/gsj_div.sv]
// Shared 64-bit restoring divider, one quotient bit per cycle.
// Depends on gsj_pkg.
`timescale 1ns / 1ps
module gsj_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  gsj_pkg::t_div_req i_req,
    output gsj_pkg::t_div_rsp o_rsp
);
    import gsj_pkg::*;

    logic        r_busy;
    logic [6:0]  r_cnt;
    logic [63:0] r_rem;
    logic [63:0] r_q;
    logic [63:0] r_d;
    logic [64:0] trial;
    logic        fits;

    assign trial = {r_rem, r_q[63]};
    assign fits  = trial >= {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= 7'd0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_cnt  <= 7'd0;
        end else if (r_busy) begin
            if (r_cnt == 7'd64) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt + 7'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= 64'd0;
            r_q   <= i_req.n;
            r_d   <= i_req.d;
        end else if (r_busy && r_cnt != 7'd64) begin
            r_rem <= fits ? 64'(trial - {1'b0, r_d}) : trial[63:0];
            r_q   <= {r_q[62:0], fits};
        end
    end

    assign o_rsp.done = r_busy && (r_cnt == 7'd64);
    assign o_rsp.q    = r_q;

endmodule

[rtl/gsj_table.sv]
// Peak parameter memory: one write port, one registered read port.
// Depends on gsj_pkg for the entry width.
`timescale 1ns / 1ps
module gsj_table #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [AW-1:0]               i_waddr,
    input  logic [gsj_pkg::ENTRY_W-1:0] i_wdata,
    input  logic [AW-1:0]               i_raddr,
    output logic [gsj_pkg::ENTRY_W-1:0] o_rdata
);
    import gsj_pkg::*;

    logic [ENTRY_W-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

[rtl/gaussian_sum_jacobian_2d.sv]
// Sum of isotropic 2D Gaussians with fit derivatives, one result per peak.
// Load transaction: accepted only while idle, no result. Evaluate transaction:
// each active peak makes 14 uses of the shared divider and up to 26 uses of the
// shared multiplier; not ready until the last result is taken. Synchronous
// active-low reset clears control and num_peaks; the peak table holds no defined
// value until written.
`timescale 1ns / 1ps
module gaussian_sum_jacobian_2d #(
    parameter int MAX_PEAKS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_wr_en,
    input  logic [4:0]   i_cfg_wr_data,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // peak_index[3:0], amplitude[35:4], center_x[67:36], center_y[99:68],
    // sigma[123:100], pixel_x[139:124], pixel_y[155:140], zero pad
    input  logic [159:0] i_s_axis_tdata,
    // mode[0]
    input  logic [0:0]   i_s_axis_tuser,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // peak_number[3:0], deriv_amplitude[51:4], deriv_center_x[99:52],
    // deriv_center_y[147:100], deriv_sigma[195:148], model_sum[259:196],
    // overflow[260], zero pad
    output logic [263:0] o_m_axis_tdata,
    output logic         o_m_axis_tlast
);
    import gsj_pkg::*;

    localparam int AW  = (MAX_PEAKS > 1) ? $clog2(MAX_PEAKS) : 1;
    localparam int CAP = (MAX_PEAKS < 16) ? MAX_PEAKS : 16;

    function automatic logic [48:0] pack48(input logic [63:0] mag, input logic neg);
        logic [63:0] m;
        logic        ov;
        ov = 1'b0;
        m  = mag;
        if (!neg) begin
            if (m > POS48) begin ov = 1'b1; m = POS48; end
            pack48 = {ov, m[47:0]};
        end else begin
            if (m > NEG48) begin ov = 1'b1; m = NEG48; end
            pack48 = {ov, 48'(64'd0 - m)};
        end
    endfunction

    t_state   r_state, n_state;
    t_mul_req mul_req;
    t_mul_rsp mul_rsp;
    t_div_req div_req;
    t_div_rsp div_rsp;

    logic [4:0]   r_num;
    logic         r_wait, n_wait;
    logic [4:0]   r_idx, n_idx;
    logic [4:0]   r_cnt, n_cnt;
    logic [15:0]  r_px, n_px, r_py, n_py;
    logic [31:0]  r_amp, n_amp;
    logic [23:0]  r_s, n_s;
    logic [31:0]  r_xm, n_xm, r_ym, n_ym;
    logic         r_xn, n_xn, r_yn, n_yn;
    logic [63:0]  r_r, n_r, r_ss, n_ss, r_inv, n_inv;
    logic [63:0]  r_tx, n_tx, r_ty, n_ty, r_tx2, n_tx2, r_u, n_u;
    logic [63:0]  r_w1, n_w1, r_w, n_w, r_y, n_y, r_term, n_term;
    logic [63:0]  r_acc, n_acc, r_e, n_e, r_h, n_h, r_g, n_g, r_gs, n_gs;
    logic [3:0]   r_k, n_k;
    logic [47:0]  r_da, n_da, r_dx, n_dx, r_dy, n_dy, r_ds, n_ds;
    logic         r_ovf, n_ovf, r_sovf, n_sovf;
    logic [63:0]  r_bsum, n_bsum;
    logic [263:0] r_odata, n_odata;
    logic         r_olast, n_olast;

    logic                 in_acc;
    logic                 out_acc;
    logic                 is_mul, is_div;
    logic                 mul_done, div_done;
    logic [ENTRY_W-1:0]   rdata;
    logic [ENTRY_W-1:0]   wdata;
    logic                 we;
    logic [31:0]          ent_a, ent_cx, ent_cy;
    logic [23:0]          ent_s;
    logic [32:0]          px_q, py_q;
    logic                 an;
    logic [63:0]          am;
    logic [63:0]          two_u;
    logic                 fneg;
    logic [63:0]          fac;
    logic [4:0]           lim_cnt;
    logic [63:0]          acc_next;
    logic [64:0]          sum_add;
    logic [48:0]          pk;
    logic                 ovf_tot;

    assign in_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign out_acc  = o_m_axis_tvalid && i_m_axis_tready;
    assign mul_done = r_wait && mul_rsp.done;
    assign div_done = r_wait && div_rsp.done;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = (r_state == S_OUT);
    assign o_m_axis_tdata  = r_odata;
    assign o_m_axis_tlast  = r_olast;

    assign ent_a  = rdata[31:0];
    assign ent_cx = rdata[63:32];
    assign ent_cy = rdata[95:64];
    assign ent_s  = rdata[119:96];
    assign px_q   = {1'b0, r_px, 16'd0};
    assign py_q   = {1'b0, r_py, 16'd0};
    assign an     = r_amp[31];
    assign am     = an ? (ONE_Q32 - {32'd0, r_amp}) : {32'd0, r_amp};
    assign two_u  = {r_u[62:0], 1'b0};
    assign fneg   = two_u < TWO_Q32;
    assign fac    = fneg ? (TWO_Q32 - two_u) : (two_u - TWO_Q32);
    assign lim_cnt = (r_num > 5'(CAP)) ? 5'(CAP) : r_num;
    assign acc_next = r_k[0] ? (r_acc - div_rsp.q) : (r_acc + div_rsp.q);

    assign we    = in_acc && !i_s_axis_tuser[0]
                   && (32'(i_s_axis_tdata[3:0]) < MAX_PEAKS);
    assign wdata = (i_s_axis_tdata[123:100] == 24'd0) ? '0 :
                   {i_s_axis_tdata[123:100], i_s_axis_tdata[99:68],
                    i_s_axis_tdata[67:36], i_s_axis_tdata[35:4]};

    gsj_table #(.DEPTH(MAX_PEAKS), .AW(AW)) u_table (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (AW'(i_s_axis_tdata[3:0])),
        .i_wdata (wdata),
        .i_raddr (AW'(r_idx)),
        .o_rdata (rdata)
    );

    gsj_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    gsj_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_comb begin
        case (r_state)
            S_MUL_SS, S_MUL_TX, S_MUL_TY, S_MUL_TXX, S_MUL_TYY, S_MUL_W1,
            S_MUL_W2, S_MUL_Y, S_MUL_T, S_MUL_H, S_MUL_G, S_MUL_GS,
            S_MUL_DX, S_MUL_DY, S_MUL_DS: begin
                is_mul = 1'b1;
                is_div = 1'b0;
            end
            S_DIV_R, S_DIV_INV, S_DIV_T: begin
                is_mul = 1'b0;
                is_div = 1'b1;
            end
            default: begin
                is_mul = 1'b0;
                is_div = 1'b0;
            end
        endcase
    end

    // unit operands
    always_comb begin
        mul_req.start = is_mul && !r_wait;
        mul_req.a     = 64'd0;
        mul_req.b     = 64'd0;
        mul_req.sh    = 6'd0;
        div_req.start = is_div && !r_wait;
        div_req.n     = RECIP_NUM;
        div_req.d     = {40'd0, r_s};
        case (r_state)
            S_MUL_SS:  begin mul_req.a = {40'd0, r_s}; mul_req.b = {40'd0, r_s}; end
            S_MUL_TX:  begin mul_req.a = {32'd0, r_xm}; mul_req.b = r_r; mul_req.sh = 6'd32; end
            S_MUL_TY:  begin mul_req.a = {32'd0, r_ym}; mul_req.b = r_r; mul_req.sh = 6'd32; end
            S_MUL_TXX: begin mul_req.a = r_tx; mul_req.b = r_tx; end
            S_MUL_TYY: begin mul_req.a = r_ty; mul_req.b = r_ty; end
            S_MUL_W1:  begin mul_req.a = {32'd0, r_u[63:32]}; mul_req.b = LOG2E_M1_Q32; end
            S_MUL_W2:  begin
                mul_req.a = {32'd0, r_u[31:0]}; mul_req.b = LOG2E_M1_Q32; mul_req.sh = 6'd32;
            end
            S_MUL_Y:   begin
                mul_req.a = {32'd0, r_w[31:0]}; mul_req.b = LN2_Q32; mul_req.sh = 6'd32;
            end
            S_MUL_T:   begin mul_req.a = r_term; mul_req.b = r_y; mul_req.sh = 6'd32; end
            S_MUL_H:   begin mul_req.a = r_inv; mul_req.b = r_e; mul_req.sh = 6'd32; end
            S_MUL_G:   begin mul_req.a = am; mul_req.b = r_h; mul_req.sh = 6'd16; end
            S_MUL_GS:  begin mul_req.a = r_g; mul_req.b = r_r; mul_req.sh = 6'd40; end
            S_MUL_DX:  begin mul_req.a = r_tx; mul_req.b = r_gs; mul_req.sh = 6'd24; end
            S_MUL_DY:  begin mul_req.a = r_ty; mul_req.b = r_gs; mul_req.sh = 6'd24; end
            S_MUL_DS:  begin mul_req.a = r_gs; mul_req.b = fac; mul_req.sh = 6'd32; end
            S_DIV_INV: begin div_req.n = INV2PI_Q64; div_req.d = r_ss; end
            S_DIV_T:   begin div_req.n = r_term; div_req.d = {60'd0, r_k}; end
            default: begin
                mul_req.sh = 6'd0;
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc && i_s_axis_tuser[0] && lim_cnt != 5'd0) begin
                    n_state = S_RD;
                end
            end
            S_RD:      n_state = S_LD;
            S_LD:      n_state = (ent_s == 24'd0) ? S_SUM : S_DIV_R;
            S_DIV_R:   if (div_done) n_state = S_MUL_SS;
            S_MUL_SS:  if (mul_done) n_state = S_DIV_INV;
            S_DIV_INV: if (div_done) n_state = S_MUL_TX;
            S_MUL_TX:  if (mul_done) n_state = S_MUL_TY;
            S_MUL_TY:  if (mul_done) n_state = S_CHK;
            S_CHK: begin
                n_state = (r_tx < TX_LIMIT && r_ty < TX_LIMIT) ? S_MUL_TXX : S_MUL_H;
            end
            S_MUL_TXX: if (mul_done) n_state = S_MUL_TYY;
            S_MUL_TYY: if (mul_done) n_state = S_CHKU;
            S_CHKU:    n_state = (r_u < U_LIMIT) ? S_MUL_W1 : S_MUL_H;
            S_MUL_W1:  if (mul_done) n_state = S_MUL_W2;
            S_MUL_W2:  if (mul_done) n_state = S_EXPN;
            S_EXPN:    n_state = (r_w[37:32] > EXP_NMAX) ? S_MUL_H : S_MUL_Y;
            S_MUL_Y:   if (mul_done) n_state = S_MUL_T;
            S_MUL_T:   if (mul_done) n_state = S_DIV_T;
            S_DIV_T: begin
                if (div_done) n_state = (r_k == EXP_TERMS) ? S_MUL_H : S_MUL_T;
            end
            S_MUL_H:   if (mul_done) n_state = S_MUL_G;
            S_MUL_G:   if (mul_done) n_state = S_MUL_GS;
            S_MUL_GS:  if (mul_done) n_state = S_MUL_DX;
            S_MUL_DX:  if (mul_done) n_state = S_MUL_DY;
            S_MUL_DY:  if (mul_done) n_state = S_MUL_DS;
            S_MUL_DS:  if (mul_done) n_state = S_SUM;
            S_SUM:     n_state = S_OUT;
            S_OUT: begin
                if (out_acc) n_state = (r_idx + 5'd1 == r_cnt) ? S_IDLE : S_RD;
            end
            default:   n_state = S_IDLE;
        endcase
    end

    // datapath
    always_comb begin
        n_wait = r_wait;
        n_idx = r_idx;   n_cnt = r_cnt;   n_px = r_px;   n_py = r_py;
        n_amp = r_amp;   n_s = r_s;       n_xm = r_xm;   n_ym = r_ym;
        n_xn = r_xn;     n_yn = r_yn;     n_r = r_r;     n_ss = r_ss;
        n_inv = r_inv;   n_tx = r_tx;     n_ty = r_ty;   n_tx2 = r_tx2;
        n_u = r_u;       n_w1 = r_w1;     n_w = r_w;     n_y = r_y;
        n_term = r_term; n_acc = r_acc;   n_e = r_e;     n_h = r_h;
        n_g = r_g;       n_gs = r_gs;     n_k = r_k;     n_da = r_da;
        n_dx = r_dx;     n_dy = r_dy;     n_ds = r_ds;   n_ovf = r_ovf;
        n_sovf = r_sovf; n_bsum = r_bsum; n_odata = r_odata; n_olast = r_olast;
        sum_add = 65'd0;
        pk      = 49'd0;
        ovf_tot = 1'b0;

        if (is_mul || is_div) begin
            if (!r_wait) begin
                n_wait = 1'b1;
            end else if (mul_done || div_done) begin
                n_wait = 1'b0;
            end
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc && i_s_axis_tuser[0]) begin
                    n_px   = i_s_axis_tdata[139:124];
                    n_py   = i_s_axis_tdata[155:140];
                    n_cnt  = lim_cnt;
                    n_idx  = 5'd0;
                    n_bsum = SUM_BIAS;
                    n_sovf = 1'b0;
                end
            end
            S_LD: begin
                n_amp = ent_a;
                n_s   = ent_s;
                n_xn  = px_q < {1'b0, ent_cx};
                n_yn  = py_q < {1'b0, ent_cy};
                n_xm  = (px_q < {1'b0, ent_cx}) ? 32'({1'b0, ent_cx} - px_q)
                                                : 32'(px_q - {1'b0, ent_cx});
                n_ym  = (py_q < {1'b0, ent_cy}) ? 32'({1'b0, ent_cy} - py_q)
                                                : 32'(py_q - {1'b0, ent_cy});
                n_u   = 64'd0;
                n_e   = 64'd0;
                n_ovf = (ent_s == 24'd0);
                n_g   = 64'd0;
                n_da  = 48'd0;
                n_dx  = 48'd0;
                n_dy  = 48'd0;
                n_ds  = 48'd0;
            end
            S_DIV_R:   if (div_done) n_r = div_rsp.q;
            S_MUL_SS:  if (mul_done) n_ss = mul_rsp.p;
            S_DIV_INV: if (div_done) n_inv = div_rsp.q;
            S_MUL_TX: begin
                if (mul_done) begin n_tx = mul_rsp.p; n_ovf = r_ovf | mul_rsp.ovf; end
            end
            S_MUL_TY: begin
                if (mul_done) begin n_ty = mul_rsp.p; n_ovf = r_ovf | mul_rsp.ovf; end
            end
            S_MUL_TXX: if (mul_done) n_tx2 = mul_rsp.p;
            S_MUL_TYY: if (mul_done) n_u = {17'd0, 47'((r_tx2 + mul_rsp.p) >> 17)};
            S_MUL_W1:  if (mul_done) n_w1 = mul_rsp.p;
            S_MUL_W2:  if (mul_done) n_w = r_u + r_w1 + mul_rsp.p;
            S_MUL_Y: begin
                if (mul_done) begin
                    n_y    = mul_rsp.p;
                    n_term = ONE_Q32;
                    n_acc  = ONE_Q32;
                    n_k    = 4'd1;
                end
            end
            S_MUL_T:   if (mul_done) n_term = mul_rsp.p;
            S_DIV_T: begin
                if (div_done) begin
                    n_term = div_rsp.q;
                    n_acc  = acc_next;
                    n_k    = r_k + 4'd1;
                    if (r_k == EXP_TERMS) begin
                        n_e = acc_next >> r_w[37:32];
                    end
                end
            end
            S_MUL_H: begin
                if (mul_done) begin
                    n_h   = mul_rsp.p;
                    pk    = pack48(mul_rsp.p, 1'b0);
                    n_da  = pk[47:0];
                    n_ovf = r_ovf | mul_rsp.ovf | pk[48];
                end
            end
            S_MUL_G: begin
                if (mul_done) begin n_g = mul_rsp.p; n_ovf = r_ovf | mul_rsp.ovf; end
            end
            S_MUL_GS: begin
                if (mul_done) begin n_gs = mul_rsp.p; n_ovf = r_ovf | mul_rsp.ovf; end
            end
            S_MUL_DX: begin
                if (mul_done) begin
                    pk    = pack48(mul_rsp.p, an != r_xn);
                    n_dx  = pk[47:0];
                    n_ovf = r_ovf | mul_rsp.ovf | pk[48];
                end
            end
            S_MUL_DY: begin
                if (mul_done) begin
                    pk    = pack48(mul_rsp.p, an != r_yn);
                    n_dy  = pk[47:0];
                    n_ovf = r_ovf | mul_rsp.ovf | pk[48];
                end
            end
            S_MUL_DS: begin
                if (mul_done) begin
                    pk    = pack48(mul_rsp.p, an != fneg);
                    n_ds  = pk[47:0];
                    n_ovf = r_ovf | mul_rsp.ovf | pk[48];
                end
            end
            S_SUM: begin
                sum_add = {1'b0, r_bsum} + {1'b0, r_g};
                n_sovf  = r_sovf;
                if (!an) begin
                    if (sum_add[64]) begin
                        n_bsum = {64{1'b1}};
                        n_sovf = 1'b1;
                    end else begin
                        n_bsum = sum_add[63:0];
                    end
                end else begin
                    if (r_g > r_bsum) begin
                        n_bsum = 64'd0;
                        n_sovf = 1'b1;
                    end else begin
                        n_bsum = r_bsum - r_g;
                    end
                end
                ovf_tot = r_ovf | n_sovf;
                n_odata = {3'd0, ovf_tot, n_bsum ^ SUM_BIAS, r_ds, r_dy, r_dx, r_da,
                           r_idx[3:0]};
                n_olast = (r_idx + 5'd1 == r_cnt);
            end
            S_OUT: begin
                if (out_acc) n_idx = r_idx + 5'd1;
            end
            default: begin
                n_wait = r_wait;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_wait  <= 1'b0;
            r_num   <= 5'd0;
        end else begin
            r_state <= n_state;
            r_wait  <= n_wait;
            if (i_cfg_wr_en) begin
                r_num <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;   r_cnt <= n_cnt;   r_px <= n_px;   r_py <= n_py;
        r_amp <= n_amp;   r_s <= n_s;       r_xm <= n_xm;   r_ym <= n_ym;
        r_xn <= n_xn;     r_yn <= n_yn;     r_r <= n_r;     r_ss <= n_ss;
        r_inv <= n_inv;   r_tx <= n_tx;     r_ty <= n_ty;   r_tx2 <= n_tx2;
        r_u <= n_u;       r_w1 <= n_w1;     r_w <= n_w;     r_y <= n_y;
        r_term <= n_term; r_acc <= n_acc;   r_e <= n_e;     r_h <= n_h;
        r_g <= n_g;       r_gs <= n_gs;     r_k <= n_k;     r_da <= n_da;
        r_dx <= n_dx;     r_dy <= n_dy;     r_ds <= n_ds;   r_ovf <= n_ovf;
        r_sovf <= n_sovf; r_bsum <= n_bsum; r_odata <= n_odata; r_olast <= n_olast;
    end

endmodule

[tb/sv/tb_gaussian_sum_jacobian_2d.sv]
// Self-checking testbench for gaussian_sum_jacobian_2d: a directed table, then random
// load/evaluate phases over several num_peaks settings, checked against a local predictor.
// Depends on gsj_pkg (fixed-point constants) and the gaussian_sum_jacobian_2d RTL.
`timescale 1ns / 1ps
module tb_gaussian_sum_jacobian_2d;
    import gsj_pkg::*;

    localparam logic    MODE_LOAD = 1'b0;
    localparam logic    MODE_EVAL = 1'b1;
    localparam int      NPEAK     = 16;
    localparam longint  LIMIT     = 4000000;
    localparam int      HOLD_CYC  = 8000;
    localparam int      NPHASE    = 8;
    localparam int      NDIR      = 23;

    typedef enum logic [1:0] {R_LOAD, R_EVAL, R_CFG} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic [3:0]  idx;
        logic [31:0] amp;
        logic [31:0] cx;
        logic [31:0] cy;
        logic [23:0] sg;
        logic [15:0] px;
        logic [15:0] py;
        logic [4:0]  cfg;
        int          cnt;
    } stim_row_t;

    typedef struct {
        logic [3:0]  pk;
        logic [47:0] da;
        logic [47:0] dx;
        logic [47:0] dy;
        logic [47:0] ds;
        logic [63:0] sum;
        logic        ovf;
        logic        last;
    } peak_result_t;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_cfg_wr_en;
    logic [4:0]   i_cfg_wr_data;
    logic         i_s_axis_tvalid;
    logic         o_s_axis_tready;
    logic [159:0] i_s_axis_tdata;
    logic [0:0]   i_s_axis_tuser;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready;
    logic [263:0] o_m_axis_tdata;
    logic         o_m_axis_tlast;

    gaussian_sum_jacobian_2d #(.MAX_PEAKS(NPEAK)) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    logic [31:0]  tab_amp [NPEAK];
    logic [31:0]  tab_cx  [NPEAK];
    logic [31:0]  tab_cy  [NPEAK];
    logic [23:0]  tab_sg  [NPEAK];
    logic [4:0]   active_peaks;
    peak_result_t jac_expect_q[$];
    int           errors, n_loads, n_evals, n_checked;
    longint       cyc;
    bit           quiet, hold_req;
    int           stall_left;

    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic logic [63:0] mulsh(input logic [63:0] a, input logic [63:0] b,
                                          input int sh, inout bit ovf);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        if ((p[127:64] >> sh) != 0) begin
            ovf = 1'b1;
            return '1;
        end
        p = p >> sh;
        return p[63:0];
    endfunction

    function automatic logic [47:0] clip48(input logic [63:0] mag, input bit neg,
                                           inout bit ovf);
        logic [63:0] m;
        m = mag;
        if (!neg) begin
            if (m > POS48) begin ovf = 1'b1; m = POS48; end
            return m[47:0];
        end
        if (m > NEG48) begin ovf = 1'b1; m = NEG48; end
        m = 64'd0 - m;
        return m[47:0];
    endfunction

    function automatic logic [63:0] exp_neg_q32(input logic [63:0] u);
        logic [63:0] w, n, y, term;
        longint      acc;
        w = u + (u >> 32) * LOG2E_M1_Q32 + (((u & 64'hFFFF_FFFF) * LOG2E_M1_Q32) >> 32);
        n = w >> 32;
        term = ONE_Q32;
        acc = longint'(ONE_Q32);
        if (n > 32) return 64'd0;
        y = ((w & 64'hFFFF_FFFF) * LN2_Q32) >> 32;
        for (int k = 1; k <= EXP_TERMS; k++) begin
            term = ((term * y) >> 32) / k;
            if (k % 2 == 1) acc -= longint'(term);
            else acc += longint'(term);
        end
        return $unsigned(acc) >> n;
    endfunction

    function automatic void offset(input logic [15:0] pix, input logic [31:0] c,
                                   output logic [63:0] mag, output bit neg);
        logic [63:0] p;
        p = {32'd0, pix, 16'd0};
        if (p >= {32'd0, c}) begin mag = p - {32'd0, c}; neg = 1'b0; end
        else begin mag = {32'd0, c} - p; neg = 1'b1; end
    endfunction

    function automatic void load_peak(input logic [3:0] idx, input logic [31:0] amp,
                                      input logic [31:0] cx, input logic [31:0] cy,
                                      input logic [23:0] sg);
        if (sg == 0) begin
            tab_amp[idx] = 0; tab_cx[idx] = 0; tab_cy[idx] = 0; tab_sg[idx] = 0;
        end else begin
            tab_amp[idx] = amp; tab_cx[idx] = cx; tab_cy[idx] = cy; tab_sg[idx] = sg;
        end
    endfunction

    function automatic int eval_pixel(input logic [15:0] px, input logic [15:0] py);
        logic [63:0]  bsum, s, r, inv, xm, ym, tx, ty, u, e, h, am, g, gs, two_u, fac;
        bit           sum_ovf, ovf, xn, yn, an, fneg;
        int           count;
        peak_result_t res;
        bsum = SUM_BIAS;
        sum_ovf = 1'b0;
        count = (active_peaks > NPEAK) ? NPEAK : int'(active_peaks);
        for (int i = 0; i < count; i++) begin
            ovf = 1'b0;
            res.da = 0; res.dx = 0; res.dy = 0; res.ds = 0;
            if (tab_sg[i] == 0) begin
                ovf = 1'b1;
            end else begin
                s = {40'd0, tab_sg[i]};
                r = RECIP_NUM / s;
                inv = INV2PI_Q64 / (s * s);
                offset(px, tab_cx[i], xm, xn);
                offset(py, tab_cy[i], ym, yn);
                tx = mulsh(xm, r, 32, ovf);
                ty = mulsh(ym, r, 32, ovf);
                u = 0;
                e = 0;
                if (tx < TX_LIMIT && ty < TX_LIMIT) begin
                    u = (tx * tx + ty * ty) >> 17;
                    if (u < U_LIMIT) e = exp_neg_q32(u);
                end
                h = mulsh(inv, e, 32, ovf);
                an = tab_amp[i][31];
                am = an ? (ONE_Q32 - {32'd0, tab_amp[i]}) : {32'd0, tab_amp[i]};
                g = mulsh(am, h, 16, ovf);
                gs = mulsh(g, r, 40, ovf);
                res.da = clip48(h, 1'b0, ovf);
                res.dx = clip48(mulsh(tx, gs, 24, ovf), an != xn, ovf);
                res.dy = clip48(mulsh(ty, gs, 24, ovf), an != yn, ovf);
                two_u = u << 1;
                fneg = two_u < TWO_Q32;
                fac = fneg ? (TWO_Q32 - two_u) : (two_u - TWO_Q32);
                res.ds = clip48(mulsh(gs, fac, 32, ovf), an != fneg, ovf);
                if (!an) begin
                    if (g > ~bsum) begin bsum = '1; sum_ovf = 1'b1; end
                    else bsum += g;
                end else begin
                    if (g > bsum) begin bsum = 0; sum_ovf = 1'b1; end
                    else bsum -= g;
                end
            end
            res.pk = 4'(i);
            res.sum = bsum ^ SUM_BIAS;
            res.ovf = ovf || sum_ovf;
            res.last = (i + 1 == count);
            jac_expect_q.push_back(res);
        end
        return count;
    endfunction

    function automatic stim_row_t mk(row_kind_t k, logic [3:0] idx, logic [31:0] amp,
                                     logic [31:0] cx, logic [31:0] cy, logic [23:0] sg,
                                     logic [15:0] px, logic [15:0] py, logic [4:0] cfg,
                                     int cnt);
        stim_row_t t;
        t.kind = k; t.idx = idx; t.amp = amp; t.cx = cx; t.cy = cy; t.sg = sg;
        t.px = px; t.py = py; t.cfg = cfg; t.cnt = cnt;
        return t;
    endfunction

    task automatic send_item(input logic m, input logic [159:0] d);
        @(negedge i_clk);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata  = d;
        i_s_axis_tuser  = m;
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    task automatic drain;
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        while (jac_expect_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_num_peaks(input logic [4:0] v);
        drain();
        repeat (40) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_wr_en = 1'b1;
        i_cfg_wr_data = v;
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
        active_peaks = v;
    endtask

    task automatic do_load(input logic [3:0] idx, input logic [31:0] amp, input logic [31:0] cx,
                           input logic [31:0] cy, input logic [23:0] sg,
                           input logic [15:0] px, input logic [15:0] py);
        send_item(MODE_LOAD, {4'd0, py, px, sg, cy, cx, amp, idx});
        load_peak(idx, amp, cx, cy, sg);
        n_loads++;
    endtask

    task automatic do_eval(input logic [3:0] idx, input logic [31:0] amp, input logic [31:0] cx,
                           input logic [31:0] cy, input logic [23:0] sg,
                           input logic [15:0] px, input logic [15:0] py, input int want);
        int got;
        send_item(MODE_EVAL, {4'd0, py, px, sg, cy, cx, amp, idx});
        got = eval_pixel(px, py);
        n_evals++;
        if (want >= 0 && got != want) begin
            $display("%0t: result count expected %0d actual %0d", $time, want, got);
            errors++;
        end
    endtask

    task automatic cmp(input string name, input logic [63:0] e, input logic [63:0] a);
        if (e !== a) begin
            $display("%0t: %s expected %h actual %h", $time, name, e, a);
            errors++;
        end
    endtask

    // receiver: random stall bursts, one long hold-off on request
    initial begin
        i_m_axis_tready = 1'b0;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_m_axis_tready = 1'b0;
                repeat (HOLD_CYC) @(negedge i_clk);
                hold_req = 1'b0;
                i_m_axis_tready = 1'b1;
            end else if (stall_left > 0) begin
                i_m_axis_tready = 1'b0;
                stall_left--;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                i_m_axis_tready = 1'b0;
                stall_left = $urandom_range(0, 11);
            end else begin
                i_m_axis_tready = 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (jac_expect_q.size() == 0) begin
                $display("%0t: unexpected result expected none actual %h", $time,
                         o_m_axis_tdata);
                errors++;
            end else begin
                peak_result_t x;
                x = jac_expect_q.pop_front();
                cmp("peak_number", 64'(x.pk), 64'(o_m_axis_tdata[3:0]));
                cmp("deriv_amplitude", 64'(x.da), 64'(o_m_axis_tdata[51:4]));
                cmp("deriv_center_x", 64'(x.dx), 64'(o_m_axis_tdata[99:52]));
                cmp("deriv_center_y", 64'(x.dy), 64'(o_m_axis_tdata[147:100]));
                cmp("deriv_sigma", 64'(x.ds), 64'(o_m_axis_tdata[195:148]));
                cmp("model_sum", x.sum, o_m_axis_tdata[259:196]);
                cmp("overflow", 64'(x.ovf), 64'(o_m_axis_tdata[260]));
                cmp("last", 64'(x.last), 64'(o_m_axis_tlast));
                n_checked++;
            end
        end
    end

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc > LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, jac_expect_q.size());
            $display("tb_gaussian_sum_jacobian_2d NOT OK");
            $finish;
        end
    end

    stim_row_t dir_tab [NDIR];
    logic [4:0] phase_np  [NPHASE] = '{5'd2, 5'd5, 5'd0, 5'd1, 5'd16, 5'd3, 5'd31, 5'd8};
    int         phase_cnt [NPHASE] = '{14, 14, 6, 14, 6, 14, 5, 14};

    function automatic logic [31:0] near_centre();
        if ($urandom_range(0, 3) != 0) return {16'($urandom_range(0, 40)), 16'($urandom)};
        return $urandom;
    endfunction

    function automatic logic [15:0] near_pixel();
        if ($urandom_range(0, 4) != 0) return 16'($urandom_range(0, 40));
        return 16'($urandom);
    endfunction

    initial begin
        logic [23:0] sg;
        int          pick;
        errors = 0; n_loads = 0; n_evals = 0; n_checked = 0; cyc = 0;
        quiet = 1'b0; hold_req = 1'b0; active_peaks = 0;
        i_rst_n = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_wr_data = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        i_s_axis_tuser = '0;
        dir_tab = '{
            mk(R_EVAL, 0, 0, 0, 0, 0, 16'd0, 16'd0, 0, 0),
            mk(R_LOAD, 0, 32'h7FFF_FFFF, 32'h000A_0000, 32'h000A_0000, 24'h000001, 0, 0, 0, -1),
            mk(R_LOAD, 1, 32'h0001_0000, 32'h000A_0000, 32'h000A_0000, 24'h000000, 0, 0, 0, -1),
            mk(R_LOAD, 2, 32'h8000_0000, 32'h000A_0000, 32'h000A_0000, 24'hFFFFFF, 0, 0, 0, -1),
            mk(R_LOAD, 3, 32'h0001_0000, 32'hFFFF_FFFF, 32'h0000_0000, 24'h010000, 0, 0, 0, -1),
            mk(R_LOAD, 4, 32'h0040_0000, 32'h000C_8000, 32'h000B_0000, 24'h020000, 0, 0, 0, -1),
            mk(R_LOAD, 5, 32'hFFC0_0000, 32'h000D_8000, 32'h000A_4000, 24'h018000, 0, 0, 0, -1),
            mk(R_LOAD, 6, 32'h0100_0000, 32'h0009_0000, 32'h000C_0000, 24'h030000, 0, 0, 0, -1),
            mk(R_LOAD, 7, 32'hFF00_0000, 32'h000A_2000, 32'h0009_8000, 24'h008000, 0, 0, 0, -1),
            mk(R_LOAD, 8, 32'h0020_0000, 32'h0010_0000, 32'h000A_0000, 24'h040000, 0, 0, 0, -1),
            mk(R_LOAD, 9, 32'h7FFF_0000, 32'h000A_0000, 32'h0010_0000, 24'h100000, 0, 0, 0, -1),
            mk(R_LOAD, 10, 32'h0000_0001, 32'h000A_0000, 32'h000A_0000, 24'h010000, 0, 0, 0, -1),
            mk(R_LOAD, 11, 32'h0080_0000, 32'h0000_0000, 32'h0000_0000, 24'h020000, 0, 0, 0, -1),
            mk(R_LOAD, 12, 32'hFFFF_FFFF, 32'h000B_0000, 32'h000B_0000, 24'h004000, 0, 0, 0, -1),
            mk(R_LOAD, 13, 32'h0040_0000, 32'h0008_0000, 32'h000E_0000, 24'h028000, 0, 0, 0, -1),
            mk(R_LOAD, 14, 32'h0010_0000, 32'hFFFF_0000, 32'hFFFF_0000, 24'h050000, 0, 0, 0, -1),
            mk(R_LOAD, 15, 32'h0060_0000, 32'h000A_8000, 32'h000A_8000, 24'h800000, 0, 0, 0, -1),
            mk(R_CFG, 0, 0, 0, 0, 0, 0, 0, 5'd4, -1),
            mk(R_EVAL, 0, 0, 0, 0, 0, 16'd10, 16'd10, 0, 4),
            mk(R_EVAL, 0, 0, 0, 0, 0, 16'd0, 16'd0, 0, 4),
            mk(R_EVAL, 0, 0, 0, 0, 0, 16'hFFFF, 16'hFFFF, 0, 4),
            mk(R_CFG, 0, 0, 0, 0, 0, 0, 0, 5'd31, -1),
            mk(R_EVAL, 0, 0, 0, 0, 0, 16'd10, 16'd11, 0, 16)
        };
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_tab[i]) begin
            case (dir_tab[i].kind)
                R_CFG: write_num_peaks(dir_tab[i].cfg);
                R_LOAD: do_load(dir_tab[i].idx, dir_tab[i].amp, dir_tab[i].cx, dir_tab[i].cy,
                                dir_tab[i].sg, dir_tab[i].px, dir_tab[i].py);
                default: do_eval(dir_tab[i].idx, dir_tab[i].amp, dir_tab[i].cx, dir_tab[i].cy,
                                 dir_tab[i].sg, dir_tab[i].px, dir_tab[i].py, dir_tab[i].cnt);
            endcase
        end

        for (int p = 0; p < NPHASE; p++) begin
            write_num_peaks(phase_np[p]);
            if (p == NPHASE - 1) quiet = 1'b1;
            if (p == 1) hold_req = 1'b1;
            for (int k = 0; k < phase_cnt[p]; k++) begin
                if (k == phase_cnt[p] / 2) drain();
                pick = $urandom_range(0, 9);
                if (pick < 7) begin
                    do_eval(4'($urandom), $urandom, $urandom, $urandom, 24'($urandom),
                            near_pixel(), near_pixel(), -1);
                end else begin
                    pick = $urandom_range(0, 9);
                    if (pick == 0) sg = 24'd0;
                    else if (pick < 8) sg = 24'($urandom_range(24'h004000, 24'h080000));
                    else sg = 24'($urandom);
                    do_load(4'($urandom), $urandom, near_centre(), near_centre(), sg,
                            16'($urandom), 16'($urandom));
                end
            end
        end

        drain();
        repeat (200) @(posedge i_clk);
        $display("covered %0d loads and %0d evaluates over %0d num_peaks settings", n_loads,
                 n_evals, NPHASE + 2);
        $display("checked %0d results, %0d mismatches", n_checked, errors);
        if (errors == 0 && jac_expect_q.size() == 0) begin
            $display("tb_gaussian_sum_jacobian_2d OK");
        end else begin
            $display("tb_gaussian_sum_jacobian_2d NOT OK");
        end
        $finish;
    end

endmodule
